### hw/rtl/sse_lfp_pkg.sv
// Shared types and constants for the event-stream line and field parser.
// No dependencies; imported by every module of the block.
package sse_lfp_pkg;

    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    localparam logic [2:0] KIND_DATA = 3'd0;
    localparam logic [2:0] KIND_DONE = 3'd4;

    localparam logic [2:0] DONE_LEN = 3'd6;

    // Field prefixes, indexed by field kind: data, event, id, retry.
    localparam logic [7:0] PREFIX_TEXT [0:3][0:7] = '{
        '{"d", "a", "t", "a", ":", " ", 8'h00, 8'h00},
        '{"e", "v", "e", "n", "t", ":", " ",   8'h00},
        '{"i", "d", ":", " ", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"r", "e", "t", "r", "y", ":", " ",   8'h00}
    };
    localparam logic [2:0] PREFIX_LEN [0:3] = '{3'd6, 3'd7, 3'd4, 3'd7};

    localparam logic [7:0] DONE_TEXT [0:7] = '{
        "[", "D", "O", "N", "E", "]", 8'h00, 8'h00
    };

    // One output transaction.
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] value;
        logic       has_byte;
        logic       last;
    } t_result;

    // Results of one input byte: a replay of held "[DONE]" bytes (data kind),
    // then up to two plain results.
    typedef struct packed {
        logic [2:0] flush_cnt;
        logic       flush_last;
        logic       p0_valid;
        t_result    p0;
        logic       p1_valid;
        t_result    p1;
    } t_desc;

endpackage

### hw/rtl/sse_lfp_parse.sv
// Line and prefix parser: holds the per-line state and turns one byte into
// a result descriptor. Depends on sse_lfp_pkg.
module sse_lfp_parse (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  logic [7:0]         i_byte,
    output sse_lfp_pkg::t_desc o_desc
);
    import sse_lfp_pkg::*;

    localparam logic [1:0] PH_MATCH = 2'd0;
    localparam logic [1:0] PH_VALUE = 2'd1;
    localparam logic [1:0] PH_SKIP  = 2'd2;

    logic [1:0] r_phase, n_phase;
    logic [2:0] r_pos, n_pos;
    logic [3:0] r_mask, n_mask;
    logic [1:0] r_kind, n_kind;
    logic       r_cr, n_cr;
    logic [2:0] r_dcnt, n_dcnt;
    logic       r_ruled, n_ruled;
    logic       r_held_v, n_held_v;
    logic [7:0] r_held_b, n_held_b;

    t_desc      desc;
    logic [3:0] next_mask;
    logic       found;
    logic [1:0] take_en;
    logic [7:0] take_b [0:1];
    logic       consumed;
    t_result    plain;

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_mask   = r_mask;
        n_kind   = r_kind;
        n_cr     = r_cr;
        n_dcnt   = r_dcnt;
        n_ruled  = r_ruled;
        n_held_v = r_held_v;
        n_held_b = r_held_b;
        desc      = '0;
        next_mask = '0;
        found     = 1'b0;
        consumed  = 1'b0;
        plain     = '0;
        take_en   = 2'b00;
        take_b[0] = CHAR_CR;
        take_b[1] = i_byte;

        case (r_phase)
            PH_MATCH: begin
                if (i_byte != CHAR_LF) begin
                    for (int k = 0; k < 4; k++) begin
                        next_mask[k] = r_mask[k] && (r_pos < PREFIX_LEN[k])
                                       && (i_byte == PREFIX_TEXT[k][r_pos]);
                    end
                    n_mask = next_mask;
                    n_pos  = r_pos + 3'd1;
                    if (next_mask == 4'd0) begin
                        n_phase = PH_SKIP;
                    end else begin
                        for (int k = 0; k < 4; k++) begin
                            if (!found && next_mask[k] && n_pos == PREFIX_LEN[k]) begin
                                found    = 1'b1;
                                n_phase  = PH_VALUE;
                                n_kind   = 2'(k);
                                n_cr     = 1'b0;
                                n_dcnt   = '0;
                                n_ruled  = 1'b0;
                                n_held_v = 1'b0;
                                n_held_b = '0;
                            end
                        end
                    end
                end
            end
            PH_VALUE: begin
                if (i_byte == CHAR_LF) begin
                    // Close the value: done marker, replayed prefix, held byte or empty.
                    if (r_kind == 2'd0 && !r_ruled && r_dcnt != 3'd0) begin
                        if (r_dcnt >= DONE_LEN) begin
                            desc.p0_valid = 1'b1;
                            desc.p0       = '{KIND_DONE, 8'h00, 1'b0, 1'b1};
                        end else begin
                            desc.flush_cnt  = r_dcnt;
                            desc.flush_last = 1'b1;
                        end
                    end else if (r_held_v) begin
                        desc.p0_valid = 1'b1;
                        desc.p0       = '{{1'b0, r_kind}, r_held_b, 1'b1, 1'b1};
                    end else begin
                        desc.p0_valid = 1'b1;
                        desc.p0       = '{{1'b0, r_kind}, 8'h00, 1'b0, 1'b1};
                    end
                end else begin
                    // A pending carriage return becomes a value byte ahead of this one.
                    take_en = {i_byte != CHAR_CR, r_cr};
                    n_cr    = (i_byte == CHAR_CR);
                    for (int t = 0; t < 2; t++) begin
                        consumed = 1'b0;
                        if (take_en[t]) begin
                            if (n_kind == 2'd0 && !n_ruled) begin
                                if (n_dcnt < DONE_LEN && take_b[t] == DONE_TEXT[n_dcnt]) begin
                                    n_dcnt   = n_dcnt + 3'd1;
                                    consumed = 1'b1;
                                end else begin
                                    n_ruled        = 1'b1;
                                    desc.flush_cnt = n_dcnt;
                                end
                            end
                            if (!consumed) begin
                                if (n_held_v) begin
                                    plain = '{{1'b0, n_kind}, n_held_b, 1'b1, 1'b0};
                                    if (!desc.p0_valid) begin
                                        desc.p0_valid = 1'b1;
                                        desc.p0       = plain;
                                    end else begin
                                        desc.p1_valid = 1'b1;
                                        desc.p1       = plain;
                                    end
                                end
                                n_held_b = take_b[t];
                                n_held_v = 1'b1;
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        // Newline restarts the line in every phase.
        if (i_byte == CHAR_LF) begin
            n_phase  = PH_MATCH;
            n_pos    = '0;
            n_mask   = 4'hF;
            n_cr     = 1'b0;
            n_dcnt   = '0;
            n_ruled  = 1'b0;
            n_held_v = 1'b0;
            n_held_b = '0;
        end
    end

    assign o_desc = desc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_MATCH;
            r_pos    <= '0;
            r_mask   <= 4'hF;
            r_kind   <= '0;
            r_cr     <= 1'b0;
            r_dcnt   <= '0;
            r_ruled  <= 1'b0;
            r_held_v <= 1'b0;
            r_held_b <= '0;
        end else if (i_advance) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_mask   <= n_mask;
            r_kind   <= n_kind;
            r_cr     <= n_cr;
            r_dcnt   <= n_dcnt;
            r_ruled  <= n_ruled;
            r_held_v <= n_held_v;
            r_held_b <= n_held_b;
        end
    end

endmodule

### hw/rtl/sse_lfp_emit.sv
// Result register and sequencer: holds one descriptor and presents its
// results one transaction per cycle while i_ready is high. Depends on sse_lfp_pkg.
module sse_lfp_emit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  sse_lfp_pkg::t_desc i_desc,
    output logic               o_can_load,
    output logic               o_valid,
    input  logic               i_ready,
    output sse_lfp_pkg::t_result o_result
);
    import sse_lfp_pkg::*;

    t_desc      r_desc;
    logic [2:0] r_idx;
    logic [2:0] flush_left;
    logic [3:0] remaining;
    logic       in_flush;
    t_result    cur;

    assign flush_left = r_desc.flush_cnt - r_idx;
    assign remaining  = {1'b0, flush_left} + {3'd0, r_desc.p0_valid}
                        + {3'd0, r_desc.p1_valid};
    assign in_flush   = (r_idx < r_desc.flush_cnt);
    assign o_valid    = (remaining != 4'd0);
    assign o_can_load = (remaining == 4'd0) || (remaining == 4'd1 && i_ready);

    always_comb begin
        if (in_flush) begin
            cur = '{KIND_DATA, DONE_TEXT[r_idx], 1'b1,
                    r_desc.flush_last && (r_idx + 3'd1 == r_desc.flush_cnt)};
        end else if (r_desc.p0_valid) begin
            cur = r_desc.p0;
        end else begin
            cur = r_desc.p1;
        end
    end

    assign o_result = cur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_desc.flush_cnt <= '0;
            r_desc.p0_valid  <= 1'b0;
            r_desc.p1_valid  <= 1'b0;
            r_idx            <= '0;
        end else if (i_load) begin
            r_desc <= i_desc;
            r_idx  <= '0;
        end else if (o_valid && i_ready) begin
            // Advance through replayed bytes first, then the plain slots in order.
            if (in_flush) begin
                r_idx <= r_idx + 3'd1;
            end else if (r_desc.p0_valid) begin
                r_desc.p0_valid <= 1'b0;
            end else begin
                r_desc.p1_valid <= 1'b0;
            end
        end
    end

endmodule

### hw/rtl/sse_line_field_parser_top.sv
// Event-stream line and field parser, top level: input register, parser, result sequencer.
// Results are registered in the sequencer. Throughput: one byte per cycle while each byte
// gives at most one result and the output is ready; a byte that gives n results (up to 7,
// when a held "[DONE]" prefix is replayed) holds the input until the sequencer's single
// output port is presenting the last of them.
// Reset (i_rst_n low, synchronous): pipeline empty, parser at the start of a line.
module sse_line_field_parser_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_stream_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_field_kind,
    output logic [7:0] o_value_byte,
    output logic       o_has_byte,
    output logic       o_value_last
);
    import sse_lfp_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       can_load;
    logic       advance;
    t_desc      desc;
    t_result    result;

    assign advance    = r_in_valid && can_load;
    assign o_in_ready = !r_in_valid || can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_stream_byte;
        end
    end

    sse_lfp_parse u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_byte    (r_in_byte),
        .o_desc    (desc)
    );

    sse_lfp_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance),
        .i_desc     (desc),
        .o_can_load (can_load),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_result   (result)
    );

    assign o_field_kind = result.kind;
    assign o_value_byte = result.value;
    assign o_has_byte   = result.has_byte;
    assign o_value_last = result.last;

endmodule
